@@ rtl/dpalu_pkg.sv @@
// Shared types and constants for the ARM data-processing ALU.
package dpalu_pkg;

    localparam int unsigned DATA_W = 32;

    // Data-processing opcodes
    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } t_alu_op;

    // Barrel shifter kinds
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } t_shift_kind;

    // True for opcodes that go through the adder
    function automatic logic is_arith(input logic [3:0] op);
        return (op == OP_SUB) || (op == OP_RSB) || (op == OP_ADD) || (op == OP_ADC) ||
               (op == OP_SBC) || (op == OP_RSC) || (op == OP_CMP) || (op == OP_CMN);
    endfunction

    // True for the compare and test opcodes, which write no result
    function automatic logic is_test(input logic [3:0] op);
        return (op == OP_TST) || (op == OP_TEQ) || (op == OP_CMP) || (op == OP_CMN);
    endfunction

endpackage

@@ rtl/arm_data_processing_alu.sv @@
// ARM data-processing ALU: barrel shifter and ALU between an input and a result register.
//
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------------
//  command   | start / busy       | i_operation, i_first_operand, shifter fields,
//            |                    | i_carry_in, i_set_flags
//  result    | o_valid (strobe)   | o_result_value, o_write_result, flag outputs
//
// One item may be started every cycle; busy is high only in and just after reset.
// Each item passes an input register and then a result register.
// The shifter and the adder share one stage between the input and result registers.
// Synchronous active-low reset clears the valid pipeline; items in flight are dropped.
// The result strobe lasts one cycle and the receiver cannot stall it.
module arm_data_processing_alu (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  dpalu_pkg::t_alu_op      i_operation,
    input  logic [31:0]             i_first_operand,
    input  logic                    i_use_immediate,
    input  logic [7:0]              i_immediate_byte,
    input  logic [3:0]              i_rotate_field,
    input  logic [31:0]             i_second_register_value,
    input  dpalu_pkg::t_shift_kind  i_shift_kind,
    input  logic                    i_shift_by_register,
    input  logic [4:0]              i_shift_immediate_amount,
    input  logic [7:0]              i_shift_register_amount,
    input  logic                    i_carry_in,
    input  logic                    i_set_flags,
    output logic                    o_valid,
    output logic [31:0]             o_result_value,
    output logic                    o_write_result,
    output logic                    o_flags_updated,
    output logic                    o_negative_out,
    output logic                    o_zero_out,
    output logic                    o_carry_out,
    output logic                    o_overflow_updated,
    output logic                    o_overflow_out
);
    import dpalu_pkg::*;

    // Control
    logic r_rdy, r_v1, r_v2;
    logic n_accept;

    // Stage 1: input register
    t_alu_op     r_op1;
    logic [31:0] r_a1, r_v;
    logic        r_use_imm, r_by_reg, r_cin1, r_sf1;
    logic [7:0]  r_imm, r_reg_amt;
    logic [3:0]  r_rot;
    t_shift_kind r_kind;
    logic [4:0]  r_imm_amt;

    // Stage 2: result register
    logic [31:0] r_res;
    logic        r_wr, r_fu, r_n, r_z, r_c, r_vu, r_ov;

    // Shifter nets
    logic [31:0] n_b;
    logic        n_sc;
    logic [4:0]  rot_amt;
    logic [63:0] imm_rot_w;
    logic [63:0] reg_rot_w;
    logic [7:0]  amt;
    logic        amt_lt32, amt_eq32;
    logic [32:0] lsl_w, lsr_w;
    logic signed [32:0] asr_w;

    // ALU nets
    logic [31:0] x, y, n_res;
    logic        ci, arith;
    logic [32:0] sum;

    assign busy     = ~r_rdy | ~i_rst_n;
    assign n_accept = start & ~busy;

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
            r_v1  <= n_accept;
            r_v2  <= r_v1;
        end
    end

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_op1     <= i_operation;
            r_a1      <= i_first_operand;
            r_use_imm <= i_use_immediate;
            r_imm     <= i_immediate_byte;
            r_rot     <= i_rotate_field;
            r_v       <= i_second_register_value;
            r_kind    <= i_shift_kind;
            r_by_reg  <= i_shift_by_register;
            r_imm_amt <= i_shift_immediate_amount;
            r_reg_amt <= i_shift_register_amount;
            r_cin1    <= i_carry_in;
            r_sf1     <= i_set_flags;
        end
    end

    // Barrel shifter: resolve the amount (immediate LSR/ASR by zero means 32)
    always_comb begin
        rot_amt   = {r_rot, 1'b0};
        imm_rot_w = {24'd0, r_imm, 24'd0, r_imm} >> rot_amt;
        if (r_by_reg) begin
            amt = r_reg_amt;
        end else if (r_imm_amt == 5'd0 && (r_kind == SH_LSR || r_kind == SH_ASR)) begin
            amt = 8'd32;
        end else begin
            amt = {3'd0, r_imm_amt};
        end
        amt_lt32  = (amt[7:5] == 3'd0);
        amt_eq32  = (amt == 8'd32);
        lsl_w     = {1'b0, r_v} << amt[4:0];
        lsr_w     = {r_v, 1'b0} >> amt[4:0];
        asr_w     = $signed({r_v, 1'b0}) >>> amt[4:0];
        reg_rot_w = {r_v, r_v} >> amt[4:0];

        n_b  = r_v;
        n_sc = r_cin1;
        if (r_use_imm) begin
            n_b = imm_rot_w[31:0];
            if (r_rot != 4'd0) begin
                n_sc = imm_rot_w[31];
            end
        end else if (!r_by_reg && r_imm_amt == 5'd0 && r_kind == SH_ROR) begin
            // RRX: carry flag enters at the top
            n_b  = {r_cin1, r_v[31:1]};
            n_sc = r_v[0];
        end else if (amt != 8'd0) begin
            unique case (r_kind)
                SH_LSL: begin
                    if (amt_lt32) begin
                        n_b  = lsl_w[31:0];
                        n_sc = lsl_w[32];
                    end else begin
                        n_b  = '0;
                        n_sc = amt_eq32 & r_v[0];
                    end
                end
                SH_LSR: begin
                    if (amt_lt32) begin
                        n_b  = lsr_w[32:1];
                        n_sc = lsr_w[0];
                    end else begin
                        n_b  = '0;
                        n_sc = amt_eq32 & r_v[31];
                    end
                end
                SH_ASR: begin
                    if (amt_lt32) begin
                        n_b  = asr_w[32:1];
                        n_sc = asr_w[0];
                    end else begin
                        n_b  = {32{r_v[31]}};
                        n_sc = r_v[31];
                    end
                end
                SH_ROR: begin
                    n_b  = reg_rot_w[31:0];
                    n_sc = reg_rot_w[31];
                end
                default: begin
                    n_b  = r_v;
                    n_sc = r_cin1;
                end
            endcase
        end
    end

    // Adder operand selection
    always_comb begin
        x     = r_a1;
        y     = n_b;
        ci    = 1'b0;
        arith = is_arith(r_op1);
        unique case (r_op1)
            OP_SUB, OP_CMP: begin
                y  = ~n_b;
                ci = 1'b1;
            end
            OP_RSB: begin
                x  = n_b;
                y  = ~r_a1;
                ci = 1'b1;
            end
            OP_ADC: begin
                ci = r_cin1;
            end
            OP_SBC: begin
                y  = ~n_b;
                ci = r_cin1;
            end
            OP_RSC: begin
                x  = n_b;
                y  = ~r_a1;
                ci = r_cin1;
            end
            default: begin
                ci = 1'b0;
            end
        endcase
        sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
    end

    // Result selection
    always_comb begin
        unique case (r_op1)
            OP_AND, OP_TST: n_res = r_a1 & n_b;
            OP_EOR, OP_TEQ: n_res = r_a1 ^ n_b;
            OP_ORR:         n_res = r_a1 | n_b;
            OP_MOV:         n_res = n_b;
            OP_BIC:         n_res = r_a1 & ~n_b;
            OP_MVN:         n_res = ~n_b;
            default:        n_res = sum[31:0];
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_res <= n_res;
            r_wr  <= ~is_test(r_op1);
            r_fu  <= r_sf1;
            r_n   <= n_res[31];
            r_z   <= (n_res == 32'd0);
            r_c   <= arith ? sum[32] : n_sc;
            r_vu  <= r_sf1 & arith;
            r_ov  <= arith & ((x[31] ^ sum[31]) & (y[31] ^ sum[31]));
        end
    end

    assign o_valid            = r_v2;
    assign o_result_value     = r_res;
    assign o_write_result     = r_wr;
    assign o_flags_updated    = r_fu;
    assign o_negative_out     = r_n;
    assign o_zero_out         = r_z;
    assign o_carry_out        = r_c;
    assign o_overflow_updated = r_vu;
    assign o_overflow_out     = r_ov;

endmodule

@@ rtl/dpalu_checker.sv @@
// Port-level checks for the ARM data-processing ALU, bound to the top level.
module dpalu_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input dpalu_pkg::t_alu_op      i_operation,
    input logic                    o_valid,
    input logic [31:0]             o_result_value,
    input logic                    o_write_result,
    input logic                    o_flags_updated,
    input logic                    o_negative_out,
    input logic                    o_zero_out,
    input logic                    o_overflow_updated
);
    import dpalu_pkg::*;

    // Every result strobe goes back to an accepted item, through the input and result registers
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy && i_rst_n, 2))
        else $error("result strobe without a matching item");

    // An item taken with no reset in between comes out through the input and result registers
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy) ##1 i_rst_n |=> o_valid)
        else $error("item lost in the pipeline");

    // Write-back follows the opcode of the item that produced the result
    a_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_write_result == !is_test($past(i_operation, 2))))
        else $error("write flag does not match opcode");

    // N and Z agree with the result word
    a_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_zero_out == (o_result_value == 32'd0)) &&
                     (o_negative_out == o_result_value[31])))
        else $error("N or Z flag disagrees with result");

    // V is only updated together with the other flags
    a_vu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_overflow_updated |-> o_flags_updated &&
            is_arith($past(i_operation, 2)))
        else $error("overflow update without flag update");

endmodule

bind arm_data_processing_alu dpalu_checker u_dpalu_checker (.*);
